// ----- sv/lqr_pkg.sv -----
`timescale 1ns / 1ps

package lqr_pkg;

  // Level format: signed fixed point, LEVEL_WIDTH bits with FRAC_BITS fraction bits.
  localparam int unsigned LEVEL_WIDTH   = 24;
  localparam int unsigned FRAC_BITS     = 16;
  localparam int unsigned STEP_WIDTH    = LEVEL_WIDTH - 1;
  localparam int unsigned WORD_WIDTH    = 32;

  // Shared multiplier operand and product widths.
  localparam int unsigned MUL_WIDTH     = 32;
  localparam int unsigned PROD_WIDTH    = 2 * MUL_WIDTH;

  // Division widths: the quotient never exceeds the range magnitude.
  localparam int unsigned QUOT_WIDTH    = LEVEL_WIDTH;
  localparam int unsigned KMAG_WIDTH    = LEVEL_WIDTH + 1;
  localparam int unsigned NUM_WIDTH     = WORD_WIDTH + LEVEL_WIDTH;
  localparam int unsigned DEN_WIDTH     = WORD_WIDTH + STEP_WIDTH;
  localparam int unsigned SUM_WIDTH     = KMAG_WIDTH + STEP_WIDTH + 2;

  localparam int unsigned CFG_IDX_WIDTH = 2;

  localparam logic [WORD_WIDTH-1:0]  LCG_MUL    = 32'd1664525;
  localparam logic [WORD_WIDTH-1:0]  LCG_ADD    = 32'd1013904223;
  localparam logic [WORD_WIDTH-1:0]  WORD_RESET = 32'h1234_5678;
  localparam logic [STEP_WIDTH-1:0]  ONE_STEP   = STEP_WIDTH'(1) << FRAC_BITS;
  localparam logic [LEVEL_WIDTH-1:0] ONE_LEVEL  = LEVEL_WIDTH'(1) << FRAC_BITS;

  localparam logic ACT_DRAW = 1'b0;
  localparam logic ACT_SEED = 1'b1;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_MIN_LEVEL = 2'd0,
    CFG_MAX_LEVEL = 2'd1,
    CFG_STEP_SIZE = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic                  action;
    logic [WORD_WIDTH-1:0] seed_value;
  } lqr_in_t;

  typedef struct packed {
    logic signed [LEVEL_WIDTH-1:0] random_value;
    logic [WORD_WIDTH-1:0]         generator_word;
  } lqr_out_t;

endpackage

// ----- sv/lqr_mul.sv -----
`timescale 1ns / 1ps

// Unsigned multiplier with a registered product, shared by every multiply of a draw.
module lqr_mul import lqr_pkg::*; (
  input  logic                  clk_i,
  input  logic [MUL_WIDTH-1:0]  a_i,
  input  logic [MUL_WIDTH-1:0]  b_i,
  output logic [PROD_WIDTH-1:0] p_o
);

  logic [PROD_WIDTH-1:0] p_q;
  logic [PROD_WIDTH-1:0] p_d;

  assign p_d = PROD_WIDTH'(a_i) * PROD_WIDTH'(b_i);

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

// ----- sv/lqr_div.sv -----
`timescale 1ns / 1ps

// Restoring divider: one quotient bit per cycle, most significant bit first.
// The caller guarantees that the quotient fits in QUOT_WIDTH bits.
module lqr_div import lqr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [NUM_WIDTH-1:0]  num_i,
  input  logic [DEN_WIDTH-1:0]  den_i,
  output logic                  done_o,
  output logic [QUOT_WIDTH-1:0] quot_o,
  output logic [DEN_WIDTH-1:0]  rem_o
);

  localparam int unsigned RW = DEN_WIDTH + QUOT_WIDTH - 1;
  localparam int unsigned CW = $clog2(QUOT_WIDTH);

  logic                  busy_q;
  logic [CW-1:0]         cnt_q;
  logic [RW-1:0]         rem_q;
  logic [RW-1:0]         div_q;
  logic [QUOT_WIDTH-1:0] quot_q;
  logic [RW-1:0]         diff;
  logic                  ge;

  assign diff   = rem_q - div_q;
  assign ge     = (rem_q >= div_q);
  assign done_o = busy_q && (cnt_q == '0);
  assign quot_o = quot_q;
  assign rem_o  = rem_q[DEN_WIDTH-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(QUOT_WIDTH - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= RW'(num_i);
      div_q <= {den_i, {(QUOT_WIDTH - 1){1'b0}}};
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= diff;
      end
      div_q  <= div_q >> 1;
      quot_q <= {quot_q[QUOT_WIDTH-2:0], ge};
    end
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !start_i |=> !busy_q && (rem_q[RW-1:DEN_WIDTH] == '0))
    else $error("divider remainder not reduced below the divisor");

  a_busy_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !done_o |=> busy_q)
    else $error("divider stopped early");

endmodule

// ----- sv/lcg_quantized_range_random_unit.sv -----
`timescale 1ns / 1ps

// A draw runs through the LCG step, numerator multiply, divider, rounding, grid multiply and sum,
// with the input stalled meanwhile; a reseed only loads the generator word, one per cycle while idle.
// The result register frees the input side: a new item is taken while a result still waits.
// Reset (asynchronous, active low): generator word 0x12345678, min 0, max 1.0, step 1.0,
// no result pending, sequencer idle.
module lcg_quantized_range_random_unit import lqr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [LEVEL_WIDTH-1:0]   cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  lqr_in_t                  in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output lqr_out_t                 out_data_o
);

  // The sequencer walks one draw through the shared multiplier and the divider.
  typedef enum logic [3:0] {
    S_IDLE,
    S_LCG_MUL,
    S_LCG_ADD,
    S_NUM_MUL,
    S_DIV_START,
    S_DIV,
    S_ROUND,
    S_K_MUL,
    S_SUM,
    S_OUT
  } state_e;

  state_e state_q;

  // Configuration and generator state.
  logic signed [LEVEL_WIDTH-1:0] min_q;
  logic signed [LEVEL_WIDTH-1:0] max_q;
  logic [STEP_WIDTH-1:0]         step_q;
  logic [WORD_WIDTH-1:0]         word_q;

  // Per-draw working registers.
  logic                          neg_q;
  logic [LEVEL_WIDTH-1:0]        mag_q;
  logic [KMAG_WIDTH-1:0]         kmag_q;
  logic signed [SUM_WIDTH-1:0]   sum_q;

  // Result register.
  logic                          out_valid_q;
  lqr_out_t                      out_data_q;

  logic                          in_accept;
  logic                          out_free;
  logic [STEP_WIDTH-1:0]         step_eff;
  logic [DEN_WIDTH-1:0]          den;
  logic [LEVEL_WIDTH:0]          range_w;
  logic [LEVEL_WIDTH:0]          mag_w;
  logic                          half_up;
  logic [KMAG_WIDTH-1:0]         kmag_d;
  logic [SUM_WIDTH-1:0]          prod_ext;
  logic signed [SUM_WIDTH-1:0]   term;
  logic signed [SUM_WIDTH-1:0]   lo_ext;
  logic signed [SUM_WIDTH-1:0]   hi_ext;
  logic signed [SUM_WIDTH-1:0]   sum_d;
  logic signed [LEVEL_WIDTH-1:0] level_d;

  logic [MUL_WIDTH-1:0]          mul_a;
  logic [MUL_WIDTH-1:0]          mul_b;
  logic [PROD_WIDTH-1:0]         mul_p;

  logic                          div_start;
  logic                          div_done;
  logic [QUOT_WIDTH-1:0]         div_quot;
  logic [DEN_WIDTH-1:0]          div_rem;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A zero step stands for one whole level unit.
  assign step_eff = (step_q == '0) ? ONE_STEP : step_q;

  // The divisor is (2^32 - 1) * step, formed as a shift and a subtract.
  assign den = {step_eff, {WORD_WIDTH{1'b0}}} - DEN_WIDTH'(step_eff);

  // Signed range and its magnitude; the magnitude always fits LEVEL_WIDTH bits.
  assign range_w = {max_q[LEVEL_WIDTH-1], max_q} - {min_q[LEVEL_WIDTH-1], min_q};
  assign mag_w   = range_w[LEVEL_WIDTH] ? (~range_w + (LEVEL_WIDTH + 1)'(1)) : range_w;

  // Round half up on the remainder: 2r >= den.
  assign half_up = ({div_rem, 1'b0} >= {1'b0, den});

  // Grid index magnitude. For a positive range the rounded quotient is taken as is. For a
  // negative range the magnitude is the quotient less one unless the fraction reached a
  // half, and a zero quotient stays zero.
  always_comb begin
    if (!neg_q) begin
      kmag_d = KMAG_WIDTH'(div_quot) + KMAG_WIDTH'(half_up);
    end else if (div_quot == '0) begin
      kmag_d = '0;
    end else begin
      kmag_d = KMAG_WIDTH'(div_quot) - KMAG_WIDTH'(!half_up);
    end
  end

  // Operand selection for the shared multiplier; the product is registered and appears in the next cycle.
  always_comb begin
    case (state_q)
      S_LCG_MUL: begin
        mul_a = word_q;
        mul_b = LCG_MUL;
      end
      S_NUM_MUL: begin
        mul_a = word_q;
        mul_b = MUL_WIDTH'(mag_q);
      end
      S_K_MUL: begin
        mul_a = MUL_WIDTH'(kmag_q);
        mul_b = MUL_WIDTH'(step_eff);
      end
      default: begin
        mul_a = word_q;
        mul_b = LCG_MUL;
      end
    endcase
  end

  // Level arithmetic: min + sign * (k magnitude * step), then the clamp in the order
  // below-min first, then above-max.
  assign prod_ext = SUM_WIDTH'(mul_p[KMAG_WIDTH+STEP_WIDTH-1:0]);
  assign term     = neg_q ? -signed'(prod_ext) : signed'(prod_ext);
  assign lo_ext   = {{(SUM_WIDTH - LEVEL_WIDTH){min_q[LEVEL_WIDTH-1]}}, min_q};
  assign hi_ext   = {{(SUM_WIDTH - LEVEL_WIDTH){max_q[LEVEL_WIDTH-1]}}, max_q};
  assign sum_d    = lo_ext + term;

  always_comb begin
    if (sum_q < lo_ext) begin
      level_d = min_q;
    end else if (sum_q > hi_ext) begin
      level_d = max_q;
    end else begin
      level_d = sum_q[LEVEL_WIDTH-1:0];
    end
  end

  assign div_start = (state_q == S_DIV_START);

  lqr_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  lqr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mul_p[NUM_WIDTH-1:0]),
    .den_i   (den),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  // Sequencer, configuration, generator word and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      min_q       <= '0;
      max_q       <= ONE_LEVEL;
      step_q      <= ONE_STEP;
      word_q      <= WORD_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MIN_LEVEL: min_q  <= cfg_data_i;
          CFG_MAX_LEVEL: max_q  <= cfg_data_i;
          CFG_STEP_SIZE: step_q <= cfg_data_i[STEP_WIDTH-1:0];
          default: ;
        endcase
      end

      // In the output state the valid is set below whenever the result register is free.
      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            if (in_data_i.action == ACT_SEED) begin
              word_q <= in_data_i.seed_value;
            end else begin
              state_q <= S_LCG_MUL;
            end
          end
        end
        S_LCG_MUL: state_q <= S_LCG_ADD;
        S_LCG_ADD: begin
          word_q  <= mul_p[WORD_WIDTH-1:0] + LCG_ADD;
          state_q <= S_NUM_MUL;
        end
        S_NUM_MUL:   state_q <= S_DIV_START;
        S_DIV_START: state_q <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            state_q <= S_ROUND;
          end
        end
        S_ROUND: state_q <= S_K_MUL;
        S_K_MUL: state_q <= S_SUM;
        S_SUM:   state_q <= S_OUT;
        S_OUT: begin
          // Wait here only while an earlier result is still held up on the output side.
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == S_LCG_ADD) begin
      neg_q <= range_w[LEVEL_WIDTH];
      mag_q <= mag_w[LEVEL_WIDTH-1:0];
    end
    if (state_q == S_ROUND) begin
      kmag_q <= kmag_d;
    end
    if (state_q == S_SUM) begin
      sum_q <= sum_d;
    end
    if (state_q == S_OUT && out_free) begin
      out_data_q.random_value   <= level_d;
      out_data_q.generator_word <= word_q;
    end
  end

  a_seed_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (in_data_i.action == ACT_SEED) |=> word_q == $past(in_data_i.seed_value))
    else $error("reseed did not load the generator word");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside the divide state");

  a_kmag_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_K_MUL |-> kmag_q <= KMAG_WIDTH'(mag_q) + KMAG_WIDTH'(1))
    else $error("grid index exceeds the range magnitude");

endmodule

// ----- bench/lcg_quantized_range_random_unit_tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the quantised range noise source. Stimulus is sent one
// transfer at a time through send_item; every accepted draw pushes its predicted
// result onto a queue, and the result checker pops and compares on each output
// transfer. Configuration is only rewritten once the block has gone quiet.
module lcg_quantized_range_random_unit_tb;
  import lqr_pkg::*;

  // An index past the register list; writes to it must leave every register alone.
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_UNUSED_IDX = 2'd3;
  // This margin covers a draw still in flight and a reseed.
  localparam int unsigned SETTLE_CYCLES = 40;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     cfg_we_i    = 1'b0;
  logic [CFG_IDX_WIDTH-1:0] cfg_idx_i   = '0;
  logic [LEVEL_WIDTH-1:0]   cfg_data_i  = '0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  lqr_in_t                  in_data_i   = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  lqr_out_t                 out_data_o;

  // Shadow copy of the block's state and registers, kept at the block's own widths.
  logic signed [LEVEL_WIDTH-1:0] lvl_min;
  logic signed [LEVEL_WIDTH-1:0] lvl_max;
  logic [STEP_WIDTH-1:0]         lvl_step;
  logic [WORD_WIDTH-1:0]         gen_word;

  // Results still owed by the block, oldest first.
  lqr_out_t pending_draws[$];

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned fail_count     = 0;

  lcg_quantized_range_random_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Advances the shadow generator word and works out the level the block should
  // produce. The grid index is the exact rounded quotient for an ordered span; for a
  // negative span the magnitude is the quotient less one unless the fraction reached a
  // half, a zero quotient stays zero, and the sign is put back afterwards.
  function automatic lqr_out_t next_draw();
    longint          lo, hi, span, k, val;
    longint unsigned step, mag, num, den, q, r;
    logic            half_up;
    lqr_out_t        res;
    gen_word = gen_word * LCG_MUL + LCG_ADD;
    lo   = longint'(lvl_min);
    hi   = longint'(lvl_max);
    step = 64'((lvl_step == '0) ? ONE_STEP : lvl_step);
    span = hi - lo;
    mag  = (span < 0) ? -span : span;
    num  = 64'(gen_word);
    num  = num * mag;
    den  = 64'hFFFF_FFFF * step;
    q    = num / den;
    r    = num % den;
    half_up = (r >= den - r);
    if (span >= 0) begin
      k = longint'(q) + longint'(half_up);
    end else if (q == 0) begin
      k = 0;
    end else begin
      k = -(longint'(q) - longint'(!half_up));
    end
    val = lo + k * longint'(step);
    // The lower bound wins, which matters when the range is inverted.
    if (val < lo) begin
      val = lo;
    end else if (val > hi) begin
      val = hi;
    end
    res.random_value   = val[LEVEL_WIDTH-1:0];
    res.generator_word = gen_word;
    return res;
  endfunction

  // One input transfer. Valid is only lowered during an idle cycle, so back-to-back
  // items keep it high without a second assignment in the same time step.
  task automatic send_item(input logic action, input logic [WORD_WIDTH-1:0] seed);
    lqr_in_t item;
    item.action     = action;
    item.seed_value = seed;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    // The transfer took place at this edge.
    if (action == ACT_SEED) begin
      gen_word = seed;
    end else begin
      pending_draws.push_back(next_draw());
    end
  endtask

  // Stops sending, waits for every owed result and then lets a possible reseed or
  // a draw still in flight settle before the registers are touched.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Single register write; the enable drops between writes.
  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                           input logic [LEVEL_WIDTH-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MIN_LEVEL: lvl_min  = value;
      CFG_MAX_LEVEL: lvl_max  = value;
      CFG_STEP_SIZE: lvl_step = value[STEP_WIDTH-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_levels(input logic [LEVEL_WIDTH-1:0] lo, input logic [LEVEL_WIDTH-1:0] hi,
                            input logic [LEVEL_WIDTH-1:0] step);
    drain();
    write_reg(CFG_MIN_LEVEL, lo);
    write_reg(CFG_MAX_LEVEL, hi);
    write_reg(CFG_STEP_SIZE, step);
  endtask

  task automatic set_idling(input int unsigned profile);
    case (profile)
      0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      1: begin src_idle_pct = 78; sink_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  sink_stall_pct = 78; end
      default: begin src_idle_pct = 11; sink_stall_pct = 11; end
    endcase
  endtask

  // Out of reset the block must draw on [0, 1.0] with a step of 1.0 from the
  // documented starting word, with no register written.
  task automatic test_reset_defaults();
    repeat (4) send_item(ACT_DRAW, $urandom);
  endtask

  // Reseeding with all-zero and all-one words, reseeds back to back, and a draw after
  // each single reseed and after the pair so the loaded word becomes visible.
  task automatic test_reseed();
    set_idling(3);
    send_item(ACT_SEED, 32'h0000_0000);
    send_item(ACT_DRAW, 32'hFFFF_FFFF);
    send_item(ACT_SEED, 32'hFFFF_FFFF);
    send_item(ACT_DRAW, 32'h0000_0000);
    send_item(ACT_SEED, 32'hAAAA_AAAA);
    send_item(ACT_SEED, 32'h5555_5555);
    send_item(ACT_DRAW, $urandom);
  endtask

  // Register corner cases: the widest range at the finest step, a zero step, a
  // step written with its unused top bit set, an inverted range, a range of one
  // level, a step that lets rounding overshoot the top, and a write to an index
  // that does not exist.
  task automatic test_level_extremes();
    set_idling(0);
    set_levels(24'h80_0000, 24'h7F_FFFF, 24'h00_0001);
    repeat (2) send_item(ACT_DRAW, $urandom);
    set_levels(24'h80_0000, 24'h7F_FFFF, 24'h00_0000);
    repeat (2) send_item(ACT_DRAW, $urandom);
    set_levels(24'h80_0000, 24'h7F_FFFF, 24'hFF_FFFF);
    repeat (2) send_item(ACT_DRAW, $urandom);
    set_levels(24'h01_0000, 24'hFF_0000, 24'h00_4000);
    repeat (2) send_item(ACT_DRAW, $urandom);
    set_levels(24'h12_3456, 24'h12_3456, 24'h00_0100);
    send_item(ACT_DRAW, $urandom);
    set_levels(24'h00_0000, 24'h03_C000, 24'h02_0000);
    drain();
    write_reg(CFG_UNUSED_IDX, 24'hFF_FFFF);
    repeat (4) send_item(ACT_DRAW, $urandom);
  endtask

  // Picks a fresh register setting from six equally likely kinds, one of them ordered
  // ranges with fine steps so that draws spread over many grid levels.
  task automatic random_config();
    logic [LEVEL_WIDTH-1:0] a, b;
    a = LEVEL_WIDTH'($urandom);
    b = LEVEL_WIDTH'($urandom);
    drain();
    case ($urandom_range(5))
      0: begin
        write_reg(CFG_MIN_LEVEL, a);
        write_reg(CFG_MAX_LEVEL, b);
        write_reg(CFG_STEP_SIZE, LEVEL_WIDTH'($urandom));
      end
      1: begin
        if ($signed(a) > $signed(b)) {a, b} = {b, a};
        write_reg(CFG_MIN_LEVEL, a);
        write_reg(CFG_MAX_LEVEL, b);
        write_reg(CFG_STEP_SIZE, LEVEL_WIDTH'($urandom_range(0, 4095)));
      end
      2: begin
        write_reg(CFG_MIN_LEVEL, 24'h80_0000);
        write_reg(CFG_MAX_LEVEL, 24'h7F_FFFF);
        case ($urandom_range(2))
          0: write_reg(CFG_STEP_SIZE, 24'h00_0000);
          1: write_reg(CFG_STEP_SIZE, 24'h00_0001);
          default: write_reg(CFG_STEP_SIZE, 24'h7F_FFFF);
        endcase
      end
      3: begin
        // Inverted: the lower register holds the larger level.
        if ($signed(a) < $signed(b)) {a, b} = {b, a};
        write_reg(CFG_MIN_LEVEL, a);
        write_reg(CFG_MAX_LEVEL, b);
        write_reg(CFG_STEP_SIZE, LEVEL_WIDTH'($urandom_range(0, 'hFFFF)));
      end
      4: begin
        write_reg(CFG_MIN_LEVEL, a);
        write_reg(CFG_MAX_LEVEL, a + LEVEL_WIDTH'($urandom_range(0, 'h3_FFFF)));
        write_reg(CFG_STEP_SIZE, LEVEL_WIDTH'($urandom_range(0, 'h1_FFFF)));
      end
      default: begin
        write_reg(CFG_MIN_LEVEL, '0);
        write_reg(CFG_MAX_LEVEL, ONE_LEVEL);
        write_reg(CFG_STEP_SIZE, LEVEL_WIDTH'($urandom_range(1) ? ONE_STEP : '0));
      end
    endcase
    write_reg(CFG_UNUSED_IDX, LEVEL_WIDTH'($urandom));
  endtask

  // Mostly draws with an occasional reseed. The seed field of a draw carries noise
  // that the block must ignore.
  task automatic random_item();
    logic [WORD_WIDTH-1:0] seed;
    seed = $urandom;
    if ($urandom_range(9) == 0) seed = $urandom_range(1) ? '1 : '0;
    if ($urandom_range(99) < 15) begin
      send_item(ACT_SEED, seed);
    end else begin
      send_item(ACT_DRAW, seed);
    end
  endtask

  // Eight phases of 250 items, each under a fresh setting, cycling through the
  // idling profiles so that gaps and stalls land on every stage of a draw.
  task automatic test_random_traffic();
    for (int phase = 0; phase < 8; phase++) begin
      set_idling(phase % 4);
      random_config();
      repeat (250) random_item();
    end
  endtask

  // Result checker: compares each output transfer against the oldest owed result
  // and chooses the stall for the next cycle.
  always @(posedge clk_i) begin : result_check
    lqr_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_draws.size() == 0) begin
        $display("%0t: unexpected result, value %0d word %h", $time,
                 out_data_o.random_value, out_data_o.generator_word);
        fail_count++;
      end else begin
        want = pending_draws.pop_front();
        if (out_data_o.random_value !== want.random_value) begin
          $display("%0t: random_value expected %0d, got %0d", $time,
                   want.random_value, out_data_o.random_value);
          fail_count++;
        end
        if (out_data_o.generator_word !== want.generator_word) begin
          $display("%0t: generator_word expected %h, got %h", $time,
                   want.generator_word, out_data_o.generator_word);
          fail_count++;
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < sink_stall_pct);
  end

  initial begin
    lvl_min  = '0;
    lvl_max  = ONE_LEVEL;
    lvl_step = ONE_STEP;
    gen_word = WORD_RESET;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_reseed();
    test_level_extremes();
    test_random_traffic();
    drain();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run, so only a hang ends up here.
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
